FILE: src/bdar_pkg.sv
// Package: shared types and constants of the button debounce and auto-repeat block.
`timescale 1ns / 1ps
package bdar_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int TIME_BITS   = 32;
    localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CMP_W       = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int ENABLE_W    = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // Button states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_JUST = 2'd1;
    localparam logic [1:0] ST_HELD = 2'd2;

    // Item modes
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_DELAY    = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_ENABLE   = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic        mode;
        logic [1:0]  button;
        logic        pin_pressed;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       fire;
        logic [1:0] press_state;
        logic       edge_ignored;
    } t_out_item;

endpackage

FILE: src/button_debounce_autorepeat_core.sv
// Top level: debounce and typematic auto-repeat for a small set of buttons.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//   cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the output is taken; o_out_valid rises after
// acceptance via the input register, then the state update and result register in one pass.
// Per-button state is read and written in the same cycle, so item after item sees
// the state left by its predecessor without stalls.
// Reset is synchronous, active low, and restores registers and button state.
// A stalled output holds its item; input stays ready while either register is free.
`timescale 1ns / 1ps
module button_debounce_autorepeat_core
    import bdar_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [15:0]         r_debounce;
    logic [31:0]         r_delay;
    logic [31:0]         r_interval;
    logic [ENABLE_W-1:0] r_enable;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic [1:0] r_state      [NUM_BUTTONS];
    t_time      r_last_edge  [NUM_BUTTONS];
    t_time      r_press      [NUM_BUTTONS];
    t_time      r_last_rep   [NUM_BUTTONS];
    logic [1:0] n_state      [NUM_BUTTONS];
    t_time      n_last_edge  [NUM_BUTTONS];
    t_time      n_press      [NUM_BUTTONS];
    t_time      n_last_rep   [NUM_BUTTONS];

    logic             w_go;
    logic             w_in_range;
    logic [BTN_W-1:0] w_idx;
    logic [3:0]       w_en_ext;
    t_time            w_now;
    t_time            w_el_edge;
    t_time            w_el_press;
    t_time            w_el_rep;
    logic             w_ignored;
    logic             w_fire;
    logic             w_cfg_wr;
    t_out_item        w_res;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = 32'(r_debounce);
            REG_DELAY:    prdata = r_delay;
            REG_INTERVAL: prdata = r_interval;
            REG_ENABLE:   prdata = 32'(r_enable);
            default:      prdata = '0;
        endcase
    end

    assign w_in_range = 32'(r_in.button) < NUM_BUTTONS;
    assign w_idx      = BTN_W'(r_in.button);
    assign w_en_ext   = 4'(r_enable);
    assign w_now      = TIME_BITS'(r_in.now_ms);
    assign w_el_edge  = w_now - r_last_edge[w_idx];
    assign w_el_press = w_now - r_press[w_idx];
    assign w_el_rep   = w_now - r_last_rep[w_idx];
    assign w_ignored  = CMP_W'(w_el_edge) < CMP_W'(r_debounce);

    always_comb begin
        n_state     = r_state;
        n_last_edge = r_last_edge;
        n_press     = r_press;
        n_last_rep  = r_last_rep;
        w_fire      = 1'b0;
        if (w_go && w_in_range) begin
            if (r_in.mode == MODE_EDGE) begin
                if (!w_ignored) begin
                    n_last_edge[w_idx] = w_now;
                    // a disabled button reads as released
                    if (w_en_ext[r_in.button] && r_in.pin_pressed) begin
                        if (r_state[w_idx] == ST_IDLE) begin
                            n_state[w_idx]    = ST_JUST;
                            n_press[w_idx]    = w_now;
                            n_last_rep[w_idx] = '0;
                        end
                    end else begin
                        n_state[w_idx]    = ST_IDLE;
                        n_last_rep[w_idx] = '0;
                    end
                end
            end else begin
                if (r_state[w_idx] == ST_JUST) begin
                    n_state[w_idx] = ST_HELD;
                    w_fire         = 1'b1;
                end else if (r_state[w_idx] == ST_HELD &&
                             CMP_W'(w_el_press) >= CMP_W'(r_delay)) begin
                    // zero tick means no repeat yet
                    if (r_last_rep[w_idx] == '0 ||
                        CMP_W'(w_el_rep) >= CMP_W'(r_interval)) begin
                        n_last_rep[w_idx] = w_now;
                        w_fire            = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        w_res = '0;
        if (w_in_range) begin
            w_res.fire         = w_fire;
            w_res.press_state  = n_state[w_idx];
            w_res.edge_ignored = (r_in.mode == MODE_EDGE) && w_ignored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= 16'd50;
            r_delay     <= 32'd500;
            r_interval  <= 32'd100;
            r_enable    <= '1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_state[i]     <= ST_IDLE;
                r_last_edge[i] <= '0;
                r_press[i]     <= '0;
                r_last_rep[i]  <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_DEBOUNCE: r_debounce <= pwdata[15:0];
                    REG_DELAY:    r_delay    <= pwdata;
                    REG_INTERVAL: r_interval <= pwdata;
                    REG_ENABLE:   r_enable   <= pwdata[ENABLE_W-1:0];
                    default:      r_enable   <= r_enable;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_state     <= n_state;
            r_last_edge <= n_last_edge;
            r_press     <= n_press;
            r_last_rep  <= n_last_rep;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_go) begin
            r_out <= w_res;
        end
    end

endmodule

FILE: src/bdar_checker.sv
// Checker: port-level assertions for the debounce core, bound to the top level.
`timescale 1ns / 1ps
module bdar_checker
    import bdar_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data
);

    // a fire leaves the button held
    a_fire_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fire |-> o_out_data.press_state == ST_HELD)
        else $error("fire reported for a button that is not held");

    // polls never flag debounce, edges never fire
    a_fire_not_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fire |-> !o_out_data.edge_ignored)
        else $error("item both fired and flagged as ignored edge");

    // input backs up only when a result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input not ready while output register is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed or dropped");

endmodule

bind button_debounce_autorepeat_core bdar_checker u_bdar_checker (.*);

FILE: tb/tb.sv
// Testbench for button_debounce_autorepeat_core: directed table plus random press episodes.
`timescale 1ns / 1ps
module tb;
    import bdar_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_KEYS  = 362;

    // stimulus table row: either a register write or one key item
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        t_in_item    it;
        bit          typed;
        t_out_item   want;
    } t_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor copy of registers and per-button state
    logic [15:0]       dbnc_ms;
    t_time             delay_ms;
    t_time             interval_ms;
    logic [2:0]        en_mask;
    logic [1:0]        btn_state    [NUM_BUTTONS];
    t_time             last_edge_ms [NUM_BUTTONS];
    t_time             press_ms     [NUM_BUTTONS];
    t_time             last_fire_ms [NUM_BUTTONS];

    t_out_item         results_due [$];
    t_row              plan [$];
    int                err_cnt      = 0;
    int                keys_done    = 0;
    int                quiet        = 0;
    int                src_idle_pct = 33;
    int                snk_idle_pct = 48;
    t_time             wall_ms      = '0;

    button_debounce_autorepeat_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    function automatic void reset_model();
        dbnc_ms     = 16'd50;
        delay_ms    = 500;
        interval_ms = 100;
        en_mask     = 3'd7;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_state[i]    = ST_IDLE;
            last_edge_ms[i] = '0;
            press_ms[i]     = '0;
            last_fire_ms[i] = '0;
        end
    endfunction

    // expected result of one key item; advances the predictor state
    function automatic t_out_item key_step(t_in_item it);
        t_out_item r;
        int        b;
        t_time     now;
        r   = '0;
        b   = int'(it.button);
        now = it.now_ms;
        if (b >= NUM_BUTTONS)
            return r;
        if (it.mode == MODE_EDGE) begin
            if (t_time'(now - last_edge_ms[b]) < dbnc_ms) begin
                r.edge_ignored = 1'b1;
            end else begin
                last_edge_ms[b] = now;
                if (b < ENABLE_W && en_mask[b] && it.pin_pressed) begin
                    if (btn_state[b] == ST_IDLE) begin
                        btn_state[b]    = ST_JUST;
                        press_ms[b]     = now;
                        last_fire_ms[b] = '0;
                    end
                end else begin
                    last_fire_ms[b] = '0;
                    btn_state[b]    = ST_IDLE;
                end
            end
        end else if (btn_state[b] == ST_JUST) begin
            btn_state[b] = ST_HELD;
            r.fire       = 1'b1;
        end else if (btn_state[b] == ST_HELD && t_time'(now - press_ms[b]) >= delay_ms) begin
            // a fire stamped at time zero reads as no fire yet
            if (last_fire_ms[b] == '0 || t_time'(now - last_fire_ms[b]) >= interval_ms) begin
                last_fire_ms[b] = now;
                r.fire          = 1'b1;
            end
        end
        r.press_state = btn_state[b];
        return r;
    endfunction

    function automatic t_in_item key_item(logic m, logic [1:0] b, logic p, t_time t);
        t_in_item it;
        it.mode        = m;
        it.button      = b;
        it.pin_pressed = p;
        it.now_ms      = t;
        return it;
    endfunction

    function automatic void key_row(logic m, logic [1:0] b, logic p, t_time t, bit typed = 0,
                                    logic f = 1'b0, logic [1:0] st = ST_IDLE,
                                    logic ign = 1'b0);
        t_row r;
        r.is_cfg            = 1'b0;
        r.idx               = REG_DEBOUNCE;
        r.val               = '0;
        r.it                = key_item(m, b, p, t);
        r.typed             = typed;
        r.want.fire         = f;
        r.want.press_state  = st;
        r.want.edge_ignored = ign;
        plan.push_back(r);
    endfunction

    function automatic void reg_row(logic [1:0] idx, logic [31:0] val);
        t_row r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.it     = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        plan.push_back(r);
    endfunction

    task automatic send_key(t_in_item it, bit typed = 0, t_out_item want = '0);
        int        gap;
        t_out_item r;
        // extend the idle gap while the given odds hold
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        r = key_step(it);
        results_due.push_back(typed ? want : r);
        keys_done++;
    endtask

    // hold input until every pending result is out, then let the pipeline settle
    task automatic drain_keys();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_reg(logic [1:0] idx, logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report($sformatf("reg %0d read %h, want %h", idx, got, want));
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE: dbnc_ms     = val[15:0];
            REG_DELAY:    delay_ms    = val;
            REG_INTERVAL: interval_ms = val;
            REG_ENABLE:   en_mask     = val[2:0];
            default: ;
        endcase
        check_reg(idx, val);
    endtask

    task automatic program_regs(logic [15:0] deb, t_time dly, t_time ivl, logic [2:0] en);
        drain_keys();
        cfg_write(REG_DEBOUNCE, {16'd0, deb});
        cfg_write(REG_DELAY, dly);
        cfg_write(REG_INTERVAL, ivl);
        cfg_write(REG_ENABLE, {29'd0, en});
    endtask

    // off-script traffic: stray buttons, bounces, far-off timestamps
    task automatic noise_key();
        case ($urandom_range(0, 3))
            0: send_key(key_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), $urandom));
            1: send_key(key_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)),
                                 1'($urandom_range(0, 1)), wall_ms));
            2: send_key(key_item(1'($urandom_range(0, 1)), 2'd3, 1'($urandom_range(0, 1)),
                                 wall_ms));
            default: send_key(key_item(MODE_EDGE, 2'($urandom_range(0, 2)),
                                       1'($urandom_range(0, 1)),
                                       wall_ms + $urandom_range(0, 30)));
        endcase
    endtask

    // press, optional bounce, a run of polls, then release
    task automatic press_episode();
        logic [1:0] b;
        int         polls;
        b = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0)
            wall_ms = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FF80;
        wall_ms += dbnc_ms + $urandom_range(0, 40);
        send_key(key_item(MODE_EDGE, b, 1'b1, wall_ms));
        if ($urandom_range(0, 3) == 0) begin
            wall_ms += $urandom_range(0, dbnc_ms);
            send_key(key_item(MODE_EDGE, b, 1'($urandom_range(0, 1)), wall_ms));
        end
        polls = $urandom_range(1, 20);
        repeat (polls) begin
            wall_ms += $urandom_range(0, 150);
            send_key(key_item(MODE_POLL, b, 1'($urandom_range(0, 1)), wall_ms));
            if ($urandom_range(0, 4) == 0)
                noise_key();
        end
        wall_ms += $urandom_range(0, dbnc_ms + 60);
        send_key(key_item(MODE_EDGE, b, 1'b0, wall_ms));
    endtask

    task automatic run_phase(int n);
        int  start;
        bit  paused;
        start  = keys_done;
        paused = 1'b0;
        while (keys_done - start < n) begin
            press_episode();
            if (!paused && keys_done - start >= n / 2) begin
                paused = 1'b1;
                drain_keys();
            end
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report($sformatf("result %h with no item pending", o_out_data));
            end else begin
                want = results_due.pop_front();
                if (o_out_data.fire !== want.fire)
                    report($sformatf("fire %b, want %b", o_out_data.fire, want.fire));
                if (o_out_data.press_state !== want.press_state)
                    report($sformatf("press_state %0d, want %0d",
                                     o_out_data.press_state, want.press_state));
                if (o_out_data.edge_ignored !== want.edge_ignored)
                    report($sformatf("edge_ignored %b, want %b",
                                     o_out_data.edge_ignored, want.edge_ignored));
            end
        end
    end

    // end the run when no item moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_DEBOUNCE, 32'd50);
        check_reg(REG_DELAY, 32'd500);
        check_reg(REG_INTERVAL, 32'd100);
        check_reg(REG_ENABLE, 32'd7);

        key_row(MODE_POLL, 2'd0, 1'b0, 32'd0, 1, 1'b0, ST_IDLE, 1'b0);
        key_row(MODE_EDGE, 2'd0, 1'b1, 32'd10, 1, 1'b0, ST_IDLE, 1'b1);
        key_row(MODE_EDGE, 2'd0, 1'b1, 32'd50, 1, 1'b0, ST_JUST, 1'b0);
        key_row(MODE_EDGE, 2'd0, 1'b1, 32'd120, 1, 1'b0, ST_JUST, 1'b0);
        key_row(MODE_POLL, 2'd0, 1'b1, 32'd130, 1, 1'b1, ST_HELD, 1'b0);
        key_row(MODE_POLL, 2'd0, 1'b0, 32'd200, 1, 1'b0, ST_HELD, 1'b0);
        key_row(MODE_POLL, 2'd0, 1'b0, 32'd550, 1, 1'b1, ST_HELD, 1'b0);
        key_row(MODE_POLL, 2'd0, 1'b0, 32'd600);
        key_row(MODE_POLL, 2'd0, 1'b0, 32'd650);
        key_row(MODE_EDGE, 2'd3, 1'b1, 32'hFFFF_FFFF, 1, 1'b0, ST_IDLE, 1'b0);
        key_row(MODE_POLL, 2'd3, 1'b1, 32'hFFFF_FFFF, 1, 1'b0, ST_IDLE, 1'b0);
        key_row(MODE_EDGE, 2'd0, 1'b0, 32'd700, 1, 1'b0, ST_IDLE, 1'b0);
        // hold across the wrap of the millisecond counter, with a fire stamped at zero
        key_row(MODE_EDGE, 2'd1, 1'b1, 32'hFFFF_FE00);
        key_row(MODE_POLL, 2'd1, 1'b1, 32'hFFFF_FE10);
        key_row(MODE_POLL, 2'd1, 1'b0, 32'd0);
        key_row(MODE_POLL, 2'd1, 1'b0, 32'd10);
        key_row(MODE_POLL, 2'd1, 1'b0, 32'd20);
        // disable button 1 while held: polls still run, presses act as releases
        reg_row(REG_ENABLE, 32'd5);
        key_row(MODE_POLL, 2'd1, 1'b0, 32'd30);
        key_row(MODE_EDGE, 2'd1, 1'b1, 32'd100);
        key_row(MODE_EDGE, 2'd1, 1'b1, 32'd120, 1, 1'b0, ST_IDLE, 1'b1);
        reg_row(REG_DEBOUNCE, 32'd0);
        key_row(MODE_EDGE, 2'd2, 1'b1, 32'd0);
        key_row(MODE_EDGE, 2'd2, 1'b0, 32'd0);
        reg_row(REG_DEBOUNCE, 32'd65535);
        key_row(MODE_EDGE, 2'd2, 1'b1, 32'd65534, 1, 1'b0, ST_IDLE, 1'b1);
        key_row(MODE_EDGE, 2'd2, 1'b1, 32'd65535);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_keys();
                cfg_write(plan[i].idx, plan[i].val);
            end else begin
                send_key(plan[i].it, plan[i].typed, plan[i].want);
            end
        end

        program_regs(16'd20, 32'd300, 32'd50, 3'b111);
        run_phase(PHASE_KEYS);
        program_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b000);
        run_phase(PHASE_KEYS);
        src_idle_pct = 48;
        snk_idle_pct = 33;
        program_regs(16'd0, 32'd0, 32'd0, 3'b101);
        run_phase(PHASE_KEYS);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_regs(16'd50, 32'd500, 32'd100, 3'b110);
        run_phase(PHASE_KEYS);

        drain_keys();
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0)
            report($sformatf("%0d results never arrived", results_due.size()));
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: button_debounce_autorepeat_core.f
src/bdar_pkg.sv
src/button_debounce_autorepeat_core.sv
src/bdar_checker.sv
tb/tb.sv
